/* rtl/svs_pkg.sv */
// Shared types and constants for the stepped voltage seek block.
package svs_pkg;

  localparam int SAMPLE_W = 12;
  localparam int MV_W = 14;
  localparam int STEP_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam int DIVIDER_GAIN_DEF = 4;

  localparam logic ACTION_START = 1'b0;
  localparam logic ACTION_SAMPLE = 1'b1;

  localparam logic [STEP_W-1:0] CMD_NONE = 2'd0;
  localparam logic [STEP_W-1:0] CMD_UP = 2'd1;
  localparam logic [STEP_W-1:0] CMD_DOWN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESET_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESET_LOW = 2'd2;

  localparam logic [MV_W-1:0] MV_MAX = 14'd16383;
  localparam logic [MV_W-1:0] TARGET_MIN_MV = 14'd2000;
  localparam logic [MV_W-1:0] TARGET_MAX_MV = 14'd9200;
  localparam logic [MV_W-1:0] SETTLE_LOW_MV = 14'd2200;
  localparam logic [MV_W-1:0] SETTLE_HIGH_MV = 14'd9000;
  localparam logic [MV_W-1:0] PRESET_HIGH_RST = 14'd9000;
  localparam logic [MV_W-1:0] PRESET_LOW_RST = 14'd2000;

  typedef struct packed {
    logic                action;
    logic [SAMPLE_W-1:0] sample_mv;
  } in_word_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_cmd;
    logic              done_res;
    logic              status;
    logic [MV_W-1:0]   final_mv;
  } out_word_t;

  typedef struct packed {
    logic [MV_W-1:0] target_mv;
    logic [MV_W-1:0] preset_high_mv;
    logic [MV_W-1:0] preset_low_mv;
  } cfg_t;

endpackage

/* rtl/svs_in_if.sv */
// Input channel: start or converter sample words.
interface svs_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [svs_pkg::SAMPLE_W-1:0] sample_mv;

  modport source (output valid, action, sample_mv, input ready);
  modport sink (input valid, action, sample_mv, output ready);
endinterface

/* rtl/svs_out_if.sv */
// Result channel: step command and run status words.
interface svs_out_if;
  logic                       valid;
  logic                       ready;
  logic [svs_pkg::STEP_W-1:0] step_cmd;
  logic                       done_res;
  logic                       status;
  logic [svs_pkg::MV_W-1:0]   final_mv;

  modport source (output valid, step_cmd, done_res, status, final_mv, input ready);
  modport sink (input valid, step_cmd, done_res, status, final_mv, output ready);
endinterface

/* rtl/svs_cfg_if.sv */
// Configuration write channel: register index and write data.
interface svs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [svs_pkg::CFG_IDX_W-1:0] index;
  logic [svs_pkg::MV_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/stepped_voltage_seek.sv */
// Stepped voltage seek top level: input register, seek sequencer, result register.
// Each input word (a start or one converter sample in mV) yields exactly one result
// word with a potentiometer step command, a done flag, an error status and the
// settled output voltage. The sample is scaled by DIVIDER_GAIN to the output
// voltage. One word is accepted every clock cycle while results are taken. The word
// waits in the input register; the combinational seek decision, with its phase
// and error registers, then loads the result register, which drives out_ch.
// While a result waits on out_ch.ready the input register still takes one more
// word, then in_ch.ready drops until the result is taken.
// Configuration words on cfg_ch are taken every cycle and should be written only
// while no word is in flight.
module stepped_voltage_seek #(
  parameter int DIVIDER_GAIN = svs_pkg::DIVIDER_GAIN_DEF
) (
  input logic       clk,
  input logic       rst_n,
  svs_in_if.sink    in_ch,
  svs_out_if.source out_ch,
  svs_cfg_if.sink   cfg_ch
);

  logic               stg_valid_r, stg_valid_nxt;
  svs_pkg::in_word_t  stg_word_r;
  logic               out_valid_r, out_valid_nxt;
  svs_pkg::out_word_t out_word_r;
  svs_pkg::out_word_t res;
  svs_pkg::cfg_t      cfg;
  logic               adv;
  logic               acc;

  svs_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  svs_core #(
    .DIVIDER_GAIN (DIVIDER_GAIN)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .item  (stg_word_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign adv = stg_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !stg_valid_r || adv;
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (acc) begin
      stg_valid_nxt = 1'b1;
    end else if (adv) begin
      stg_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      stg_word_r.action <= in_ch.action;
      stg_word_r.sample_mv <= in_ch.sample_mv;
    end
    if (adv) begin
      out_word_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.step_cmd = out_word_r.step_cmd;
  assign out_ch.done_res = out_word_r.done_res;
  assign out_ch.status = out_word_r.status;
  assign out_ch.final_mv = out_word_r.final_mv;

`ifndef SYNTHESIS
  a_status_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.status |-> out_word_r.done_res)
    else $error("error status without done");

  a_final_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word_r.done_res |-> out_word_r.final_mv == '0)
    else $error("final voltage reported before done");

  a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r && !out_valid_r |=> out_valid_r)
    else $error("staged word not moved to result register");
`endif

endmodule

/* rtl/svs_cfg_regs.sv */
// Configuration register file: target and preset thresholds.
module svs_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  svs_cfg_if.sink       cfg_ch,
  output svs_pkg::cfg_t cfg
);

  svs_pkg::cfg_t cfg_r;
  svs_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        svs_pkg::REG_TARGET: cfg_nxt.target_mv = cfg_ch.data;
        svs_pkg::REG_PRESET_HIGH: cfg_nxt.preset_high_mv = cfg_ch.data;
        svs_pkg::REG_PRESET_LOW: cfg_nxt.preset_low_mv = cfg_ch.data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_mv <= '0;
      cfg_r.preset_high_mv <= svs_pkg::PRESET_HIGH_RST;
      cfg_r.preset_low_mv <= svs_pkg::PRESET_LOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/svs_core.sv */
// Seek sequencer: run phase, stored error and the per-word decision.
module svs_core #(
  parameter int DIVIDER_GAIN = svs_pkg::DIVIDER_GAIN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  svs_pkg::in_word_t  item,
  input  svs_pkg::cfg_t      cfg,
  output svs_pkg::out_word_t res
);

  localparam int V_W = svs_pkg::SAMPLE_W + $clog2(DIVIDER_GAIN + 1);
  localparam int CMP_W = (V_W > svs_pkg::MV_W) ? V_W : svs_pkg::MV_W + 1;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_PRE_DOWN = 3'd1;
  localparam logic [2:0] PH_PRE_UP = 3'd2;
  localparam logic [2:0] PH_SEEK_PRE = 3'd3;
  localparam logic [2:0] PH_SEEK_POST = 3'd4;
  localparam logic [2:0] PH_FINAL = 3'd5;

  logic [2:0]              phase_r, phase_nxt;
  logic [svs_pkg::MV_W-1:0] prior_err_r, prior_err_nxt;
  logic                    moved_up_r, moved_up_nxt;

  logic [V_W-1:0]          v;
  logic [CMP_W-1:0]        vx, tx, hx, lx, diff;
  logic [svs_pkg::MV_W-1:0] err, v_sat;
  logic                    check;

  assign v = V_W'(item.sample_mv) * V_W'(DIVIDER_GAIN);
  assign vx = CMP_W'(v);
  assign tx = CMP_W'(cfg.target_mv);
  assign hx = CMP_W'(cfg.preset_high_mv);
  assign lx = CMP_W'(cfg.preset_low_mv);
  assign diff = (tx > vx) ? tx - vx : vx - tx;
  assign err = (diff > CMP_W'(svs_pkg::MV_MAX)) ? svs_pkg::MV_MAX : diff[svs_pkg::MV_W-1:0];
  assign v_sat = (vx > CMP_W'(svs_pkg::MV_MAX)) ? svs_pkg::MV_MAX : vx[svs_pkg::MV_W-1:0];

  always_comb begin
    res = '0;
    res.step_cmd = svs_pkg::CMD_NONE;
    check = 1'b0;
    phase_nxt = phase_r;
    prior_err_nxt = prior_err_r;
    moved_up_nxt = moved_up_r;
    if (item.action == svs_pkg::ACTION_START) begin
      phase_nxt = PH_PRE_DOWN;
    end else begin
      case (phase_r)
        PH_PRE_DOWN: begin
          if (vx > hx) begin
            res.step_cmd = svs_pkg::CMD_DOWN;
          end else if (vx < lx) begin
            res.step_cmd = svs_pkg::CMD_UP;
            phase_nxt = PH_PRE_UP;
          end else begin
            check = 1'b1;
          end
        end
        PH_PRE_UP: begin
          if (vx < lx) begin
            res.step_cmd = svs_pkg::CMD_UP;
          end else begin
            check = 1'b1;
          end
        end
        PH_SEEK_PRE: begin
          prior_err_nxt = err;
          if (vx < tx) begin
            res.step_cmd = svs_pkg::CMD_UP;
            moved_up_nxt = 1'b1;
          end else begin
            res.step_cmd = svs_pkg::CMD_DOWN;
            moved_up_nxt = 1'b0;
          end
          phase_nxt = PH_SEEK_POST;
        end
        PH_SEEK_POST: begin
          if (prior_err_r < err) begin
            res.step_cmd = moved_up_r ? svs_pkg::CMD_DOWN : svs_pkg::CMD_UP;
            phase_nxt = PH_FINAL;
          end else if (prior_err_r == err && vx < CMP_W'(svs_pkg::SETTLE_HIGH_MV)
                       && vx > CMP_W'(svs_pkg::SETTLE_LOW_MV)) begin
            phase_nxt = PH_FINAL;
          end else begin
            phase_nxt = PH_SEEK_PRE;
          end
        end
        PH_FINAL: begin
          res.done_res = 1'b1;
          res.final_mv = v_sat;
          phase_nxt = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
    if (check) begin
      if (cfg.target_mv > svs_pkg::TARGET_MAX_MV || cfg.target_mv < svs_pkg::TARGET_MIN_MV) begin
        res.done_res = 1'b1;
        res.status = 1'b1;
        phase_nxt = PH_IDLE;
      end else begin
        phase_nxt = PH_SEEK_PRE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      prior_err_r <= '0;
      moved_up_r <= 1'b0;
    end else if (en) begin
      phase_r <= phase_nxt;
      prior_err_r <= prior_err_nxt;
      moved_up_r <= moved_up_nxt;
    end
  end

`ifndef SYNTHESIS
  a_start_enters_preset: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.action == svs_pkg::ACTION_START |=> phase_r == PH_PRE_DOWN)
    else $error("start word did not enter preset stage");

  a_pre_goes_post: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.action == svs_pkg::ACTION_SAMPLE && phase_r == PH_SEEK_PRE
    |=> phase_r == PH_SEEK_POST)
    else $error("pre-step sample did not advance to post-step");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.action == svs_pkg::ACTION_SAMPLE && phase_r == PH_IDLE
    |-> res.step_cmd == svs_pkg::CMD_NONE && !res.done_res && !res.status)
    else $error("sample while idle produced activity");
`endif

endmodule

/* tb/sv/stepped_voltage_seek_checker.sv */
// Checker for stepped_voltage_seek: predicts each result word and compares it with the output.
`timescale 1ns / 100ps

module stepped_voltage_seek_checker (
  input  logic clk,
  input  logic rst_n,
  svs_in_if    in_ch,
  svs_out_if   out_ch,
  svs_cfg_if   cfg_ch,
  output int   fail_cnt,
  output int   words_pending,
  output int   runs_done
);

  typedef enum logic [2:0] {
    SEEK_IDLE,
    SEEK_PRESET_DOWN,
    SEEK_PRESET_UP,
    SEEK_PRE_STEP,
    SEEK_POST_STEP,
    SEEK_REPORT
  } seek_phase_t;

  seek_phase_t              seek_phase;
  logic [svs_pkg::MV_W-1:0] err_before_step;
  logic                     stepped_up;
  logic [svs_pkg::MV_W-1:0] target_reg;
  logic [svs_pkg::MV_W-1:0] high_reg;
  logic [svs_pkg::MV_W-1:0] low_reg;
  svs_pkg::out_word_t       expected_q[$];
  int                       fails;
  int                       finished;
  int                       results_seen;

  function automatic logic [svs_pkg::MV_W-1:0] clipped_err(input logic [15:0] a,
                                                          input logic [15:0] b);
    logic [15:0] d;
    d = (a > b) ? a - b : b - a;
    return (d > 16'(svs_pkg::MV_MAX)) ? svs_pkg::MV_MAX : d[svs_pkg::MV_W-1:0];
  endfunction

  function automatic svs_pkg::out_word_t next_result(input svs_pkg::in_word_t w);
    logic [15:0]              volts;
    logic [svs_pkg::MV_W-1:0] err_now;
    logic                     judge_target;
    svs_pkg::out_word_t       r;
    volts = 16'(w.sample_mv) * 16'(svs_pkg::DIVIDER_GAIN_DEF);
    r = '0;
    judge_target = 1'b0;
    if (w.action == svs_pkg::ACTION_START) begin
      seek_phase = SEEK_PRESET_DOWN;
    end else begin
      case (seek_phase)
        SEEK_PRESET_DOWN: begin
          if (volts > 16'(high_reg)) begin
            r.step_cmd = svs_pkg::CMD_DOWN;
          end else if (volts < 16'(low_reg)) begin
            r.step_cmd = svs_pkg::CMD_UP;
            seek_phase = SEEK_PRESET_UP;
          end else begin
            judge_target = 1'b1;
          end
        end
        SEEK_PRESET_UP: begin
          if (volts < 16'(low_reg)) r.step_cmd = svs_pkg::CMD_UP;
          else judge_target = 1'b1;
        end
        SEEK_PRE_STEP: begin
          err_before_step = clipped_err(16'(target_reg), volts);
          if (volts < 16'(target_reg)) begin
            r.step_cmd = svs_pkg::CMD_UP;
            stepped_up = 1'b1;
          end else begin
            r.step_cmd = svs_pkg::CMD_DOWN;
            stepped_up = 1'b0;
          end
          seek_phase = SEEK_POST_STEP;
        end
        SEEK_POST_STEP: begin
          err_now = clipped_err(16'(target_reg), volts);
          if (err_before_step < err_now) begin
            r.step_cmd = stepped_up ? svs_pkg::CMD_DOWN : svs_pkg::CMD_UP;
            seek_phase = SEEK_REPORT;
          end else if (err_before_step == err_now
                       && volts < 16'(svs_pkg::SETTLE_HIGH_MV)
                       && volts > 16'(svs_pkg::SETTLE_LOW_MV)) begin
            seek_phase = SEEK_REPORT;
          end else begin
            seek_phase = SEEK_PRE_STEP;
          end
        end
        SEEK_REPORT: begin
          r.done_res = 1'b1;
          r.final_mv = (volts > 16'(svs_pkg::MV_MAX)) ? svs_pkg::MV_MAX
                                                      : volts[svs_pkg::MV_W-1:0];
          seek_phase = SEEK_IDLE;
        end
        default: seek_phase = SEEK_IDLE;
      endcase
    end
    if (judge_target) begin
      if (target_reg > svs_pkg::TARGET_MAX_MV || target_reg < svs_pkg::TARGET_MIN_MV) begin
        r.done_res = 1'b1;
        r.status = 1'b1;
        seek_phase = SEEK_IDLE;
      end else begin
        seek_phase = SEEK_PRE_STEP;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    svs_pkg::in_word_t  taken;
    svs_pkg::out_word_t want;
    svs_pkg::out_word_t got;
    if (!rst_n) begin
      seek_phase = SEEK_IDLE;
      err_before_step = '0;
      stepped_up = 1'b0;
      target_reg = '0;
      high_reg = svs_pkg::PRESET_HIGH_RST;
      low_reg = svs_pkg::PRESET_LOW_RST;
      expected_q.delete();
      fails = 0;
      finished = 0;
      results_seen = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          svs_pkg::REG_TARGET:      target_reg = cfg_ch.data;
          svs_pkg::REG_PRESET_HIGH: high_reg = cfg_ch.data;
          svs_pkg::REG_PRESET_LOW:  low_reg = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        taken.action = in_ch.action;
        taken.sample_mv = in_ch.sample_mv;
        expected_q.push_back(next_result(taken));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.step_cmd = out_ch.step_cmd;
        got.done_res = out_ch.done_res;
        got.status = out_ch.status;
        got.final_mv = out_ch.final_mv;
        results_seen++;
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display({"result word %0d arrived with nothing expected: ",
                      "step %0d done %0d status %0d final %0d"},
                     results_seen, got.step_cmd, got.done_res, got.status, got.final_mv);
        end else begin
          want = expected_q.pop_front();
          if (got.step_cmd !== want.step_cmd || got.done_res !== want.done_res
              || got.status !== want.status || got.final_mv !== want.final_mv) begin
            fails++;
            if (fails <= 10)
              $display({"result word %0d mismatch: expected step %0d done %0d status %0d ",
                        "final %0d, got step %0d done %0d status %0d final %0d"},
                       results_seen, want.step_cmd, want.done_res, want.status,
                       want.final_mv, got.step_cmd, got.done_res, got.status,
                       got.final_mv);
          end
          if (want.done_res) finished++;
        end
      end
    end
    fail_cnt <= fails;
    words_pending <= expected_q.size();
    runs_done <= finished;
  end

endmodule

/* tb/sv/stepped_voltage_seek_test.sv */
// Testbench top for stepped_voltage_seek: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module stepped_voltage_seek_test;

  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 115;
  localparam logic [svs_pkg::MV_W-1:0] MV_TOP = 14'd13200;

  logic clk = 1'b0;
  logic rst_n;

  int gap_mode;
  int stall_mode;
  int fail_cnt;
  int words_pending;
  int runs_done;
  int words_sent;
  int runs_started;
  int settings_used;

  logic [svs_pkg::MV_W-1:0]     target_now;
  logic [svs_pkg::SAMPLE_W-1:0] last_sample;
  logic [svs_pkg::MV_W-1:0]     odd_targets [7] = '{14'd0, 14'd1999, 14'd2000, 14'd9200,
                                                    14'd9201, 14'd13200, 14'd16383};

  svs_in_if  in_ch ();
  svs_out_if out_ch ();
  svs_cfg_if cfg_ch ();

  stepped_voltage_seek dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  stepped_voltage_seek_checker seek_watch (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_cnt      (fail_cnt),
    .words_pending (words_pending),
    .runs_done     (runs_done)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("stepped_voltage_seek test failed");
    $finish;
  end

  function automatic int draw_wait(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(16);
      default: return ($urandom_range(3) == 0) ? $urandom_range(16) : 0;
    endcase
  endfunction

  function automatic logic [svs_pkg::SAMPLE_W-1:0] next_sample();
    int pick;
    int s;
    pick = $urandom_range(9);
    if (pick < 2) s = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(3300);
    else if (pick < 4) s = last_sample;
    else s = int'(target_now) / svs_pkg::DIVIDER_GAIN_DEF + int'($urandom_range(80)) - 40;
    if (s < 0) s = 0;
    if (s > 4095) s = 4095;
    return s[svs_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic send_word(input logic act, input logic [svs_pkg::SAMPLE_W-1:0] smp);
    int gap;
    gap = draw_wait(gap_mode);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.sample_mv <= smp;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (act == svs_pkg::ACTION_START) runs_started++;
    else last_sample = smp;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [svs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [svs_pkg::MV_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == svs_pkg::REG_TARGET) target_now = val;
  endtask

  task automatic configure(input logic [svs_pkg::MV_W-1:0] tgt,
                           input logic [svs_pkg::MV_W-1:0] hi,
                           input logic [svs_pkg::MV_W-1:0] lo);
    drain();
    write_reg(svs_pkg::REG_TARGET, tgt);
    write_reg(svs_pkg::REG_PRESET_HIGH, hi);
    write_reg(svs_pkg::REG_PRESET_LOW, lo);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_run();
    int len;
    if ($urandom_range(7) == 0) send_word(svs_pkg::ACTION_SAMPLE, next_sample());
    send_word(svs_pkg::ACTION_START, 12'($urandom_range(4095)));
    len = $urandom_range(14, 1);
    repeat (len) send_word(svs_pkg::ACTION_SAMPLE, next_sample());
  endtask

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait(stall_mode);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    int phase_start;
    logic [svs_pkg::MV_W-1:0] tgt;
    logic [svs_pkg::MV_W-1:0] hi;
    logic [svs_pkg::MV_W-1:0] lo;
    in_ch.valid <= 1'b0;
    in_ch.action <= svs_pkg::ACTION_START;
    in_ch.sample_mv <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= svs_pkg::REG_TARGET;
    cfg_ch.data <= '0;
    rst_n <= 1'b0;
    gap_mode = 2;
    stall_mode = 2;
    words_sent = 0;
    runs_started = 0;
    settings_used = 0;
    target_now = '0;
    last_sample = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: target 0 is out of range
    send_word(svs_pkg::ACTION_SAMPLE, 12'd0);
    send_word(svs_pkg::ACTION_START, 12'd4095);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd4095);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd0);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd300);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd600);

    configure(14'd5000, svs_pkg::PRESET_HIGH_RST, svs_pkg::PRESET_LOW_RST);
    // settle on unchanged error, then on growing error with step back
    send_word(svs_pkg::ACTION_START, 12'd0);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd1250);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd1200);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd1225);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd1240);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd1260);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd1250);
    send_word(svs_pkg::ACTION_START, 12'd0);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd1250);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd1300);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd1350);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd3300);
    // abandon a run in the preset stage and in the seek
    send_word(svs_pkg::ACTION_START, 12'd0);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd2300);
    send_word(svs_pkg::ACTION_START, 12'd0);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd1250);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd1250);

    configure(svs_pkg::TARGET_MIN_MV, svs_pkg::PRESET_HIGH_RST, svs_pkg::PRESET_LOW_RST);
    // unchanged error below the settle window keeps seeking
    send_word(svs_pkg::ACTION_START, 12'd0);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd500);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd500);
    send_word(svs_pkg::ACTION_SAMPLE, 12'd500);
    send_word(svs_pkg::ACTION_START, 12'd0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          tgt = svs_pkg::TARGET_MAX_MV;
          hi = MV_TOP;
          lo = '0;
        end
        1: begin
          tgt = svs_pkg::TARGET_MIN_MV;
          hi = '0;
          lo = MV_TOP;
        end
        default: begin
          tgt = ($urandom_range(3) == 0) ? odd_targets[$urandom_range(6)]
                                         : 14'($urandom_range(9200, 2000));
          hi = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? 14'd0 : MV_TOP)
                                        : 14'($urandom_range(10000, 8000));
          lo = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? 14'd0 : MV_TOP)
                                        : 14'($urandom_range(2500, 1500));
        end
      endcase
      configure(tgt, hi, lo);
      gap_mode = (p == 0) ? 1 : $urandom_range(2);
      stall_mode = (p == 1) ? 0 : $urandom_range(2);
      phase_start = words_sent;
      while (words_sent - phase_start < WORDS_PER_PHASE) random_run();
    end

    drain();
    $display("sent %0d words in %0d runs across %0d register settings", words_sent,
             runs_started, settings_used);
    $display("%0d runs reported done", runs_done);
    if (fail_cnt == 0) begin
      $display("stepped_voltage_seek test passed");
    end else begin
      $display("stepped_voltage_seek test failed");
    end
    $finish;
  end

endmodule
